FILE: rtl/bls_pkg.sv
`timescale 1ns / 1ps
package bls_pkg;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_HELLO   = 3'd1,
    PH_PROFILE = 3'd2,
    PH_QUERY   = 3'd3,
    PH_STATUS  = 3'd4,
    PH_FAIL    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_HELLO   = 2'd1,
    REQ_PROFILE = 2'd2,
    REQ_STATUS  = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_MAX_FAIL = 2'd1;

  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned MAXFAIL_W = 8;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned FAILCNT_W = 9;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd5;
  localparam logic [MAXFAIL_W-1:0] MAXFAIL_RST  = 8'd10;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 17'h1FFFF;
  localparam logic [FAILCNT_W-1:0] FAILCNT_MAX  = 9'h1FF;

  // reply latch bit positions
  localparam int unsigned LATCH_HELLO   = 0;
  localparam int unsigned LATCH_PROFILE = 1;
  localparam int unsigned LATCH_STATUS  = 2;

  typedef struct packed {
    logic tick;
    logic tx_busy;
    logic hello_reply;
    logic profile_reply;
    logic status_reply;
  } poll_t;

  typedef struct packed {
    req_t   request;
    phase_t phase;
    logic   com_error;
    logic   locked_out;
  } result_t;

endpackage

FILE: rtl/bls_in_stage.sv
`timescale 1ns / 1ps
module bls_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bls_pkg::poll_t in_poll,
  input  logic           advance,
  output logic           poll_valid,
  output bls_pkg::poll_t poll
);

  logic           valid_r;
  logic           valid_nxt;
  bls_pkg::poll_t poll_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign poll_valid = valid_r;
  assign poll       = poll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_r <= in_poll;
    end
  end

endmodule

FILE: rtl/bls_core.sv
`timescale 1ns / 1ps
module bls_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  bls_pkg::poll_t                  poll,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [bls_pkg::TIMEOUT_W-1:0]   cfg_data,
  output bls_pkg::result_t                res
);

  logic [bls_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [bls_pkg::MAXFAIL_W-1:0] maxfail_r;

  bls_pkg::phase_t               phase_r,   phase_nxt;
  logic [bls_pkg::ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [2:0]                    latch_r,   latch_nxt;
  logic [bls_pkg::FAILCNT_W-1:0] failcnt_r, failcnt_nxt;
  logic                          lock_r,    lock_nxt;
  logic                          alarm_r,   alarm_nxt;

  logic [bls_pkg::ELAPSED_W-1:0] el_tick;
  logic [2:0]                    lat_in;
  logic [bls_pkg::ELAPSED_W-1:0] to_ext;
  logic [bls_pkg::FAILCNT_W-1:0] fc_inc;
  logic                          wait_bit;
  logic                          in_time;
  logic                          late;
  bls_pkg::phase_t               wait_next;
  bls_pkg::req_t                 req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= bls_pkg::TIMEOUT_RST;
      maxfail_r <= bls_pkg::MAXFAIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bls_pkg::CFG_TIMEOUT:  timeout_r <= cfg_data;
        bls_pkg::CFG_MAX_FAIL: maxfail_r <= cfg_data[bls_pkg::MAXFAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= bls_pkg::PH_OFF;
      elapsed_r <= '0;
      latch_r   <= '0;
      failcnt_r <= '0;
      lock_r    <= 1'b0;
      alarm_r   <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      latch_r   <= latch_nxt;
      failcnt_r <= failcnt_nxt;
      lock_r    <= lock_nxt;
      alarm_r   <= alarm_nxt;
    end
  end

  always_comb begin
    el_tick = (poll.tick && elapsed_r != bls_pkg::ELAPSED_MAX) ?
              elapsed_r + 17'd1 : elapsed_r;
    lat_in  = latch_r | {poll.status_reply, poll.profile_reply, poll.hello_reply};
    to_ext  = {1'b0, timeout_r};
    late    = el_tick > to_ext;
    in_time = el_tick < to_ext;
    fc_inc  = (failcnt_r != bls_pkg::FAILCNT_MAX) ? failcnt_r + 9'd1 : failcnt_r;

    wait_bit  = 1'b0;
    wait_next = bls_pkg::PH_FAIL;
    case (phase_r)
      bls_pkg::PH_HELLO: begin
        wait_bit  = lat_in[bls_pkg::LATCH_HELLO];
        wait_next = bls_pkg::PH_PROFILE;
      end
      bls_pkg::PH_PROFILE: begin
        wait_bit  = lat_in[bls_pkg::LATCH_PROFILE];
        wait_next = bls_pkg::PH_QUERY;
      end
      bls_pkg::PH_STATUS: begin
        wait_bit  = lat_in[bls_pkg::LATCH_STATUS];
        wait_next = bls_pkg::PH_QUERY;
      end
      default: ;
    endcase

    phase_nxt   = phase_r;
    elapsed_nxt = el_tick;
    latch_nxt   = lat_in;
    failcnt_nxt = failcnt_r;
    lock_nxt    = lock_r;
    alarm_nxt   = alarm_r;
    req         = bls_pkg::REQ_NONE;

    if (!poll.tx_busy) begin
      unique case (phase_r)
        bls_pkg::PH_OFF: begin
          req         = bls_pkg::REQ_HELLO;
          phase_nxt   = bls_pkg::PH_HELLO;
          elapsed_nxt = '0;
        end
        bls_pkg::PH_HELLO, bls_pkg::PH_PROFILE, bls_pkg::PH_STATUS: begin
          if (wait_bit && in_time) begin
            phase_nxt   = wait_next;
            elapsed_nxt = '0;
            if (phase_r == bls_pkg::PH_HELLO) begin
              req = bls_pkg::REQ_PROFILE;
            end
          end else if (late) begin
            phase_nxt   = bls_pkg::PH_FAIL;
            elapsed_nxt = '0;
          end
        end
        bls_pkg::PH_QUERY: begin
          req         = bls_pkg::REQ_STATUS;
          phase_nxt   = bls_pkg::PH_STATUS;
          elapsed_nxt = '0;
          // drop any status answer seen in the same poll as the query
          latch_nxt[bls_pkg::LATCH_STATUS] = 1'b0;
        end
        bls_pkg::PH_FAIL: begin
          if (!lock_r) begin
            if (late) begin
              failcnt_nxt = fc_inc;
              elapsed_nxt = '0;
              if (fc_inc > {1'b0, maxfail_r}) begin
                lock_nxt = 1'b1;
              end else begin
                phase_nxt = bls_pkg::PH_OFF;
                latch_nxt = '0;
              end
            end
          end else begin
            alarm_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end

    res.request    = req;
    res.phase      = phase_nxt;
    res.com_error  = alarm_nxt;
    res.locked_out = lock_nxt;
  end

endmodule

FILE: rtl/bls_out_stage.sv
`timescale 1ns / 1ps
module bls_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  bls_pkg::result_t res,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output bls_pkg::result_t out_res
);

  logic             valid_r;
  logic             valid_nxt;
  bls_pkg::result_t res_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

FILE: rtl/link_bringup_sequencer.sv
`timescale 1ns / 1ps
// Path: a poll waits in the input register, then its result in the result
// register. Throughput: one poll per cycle unless out_ready stalls; the input
// and result registers let a new poll enter while a result waits on out_ready.
// Reset: synchronous on rst_n low; phase off, timers, latches, failure count,
// lockout and alarm cleared, timeout back to 5 and failure limit back to 10.
module link_bringup_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_tick,
  input  logic        in_tx_busy,
  input  logic        in_hello_reply,
  input  logic        in_profile_reply,
  input  logic        in_status_reply,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_request,
  output logic [2:0]  out_phase,
  output logic        out_com_error,
  output logic        out_locked_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bls_pkg::poll_t   in_poll;
  bls_pkg::poll_t   poll;
  bls_pkg::result_t res;
  bls_pkg::result_t out_res;
  logic             poll_valid;
  logic             slot_free;
  logic             advance;

  assign in_poll.tick          = in_tick;
  assign in_poll.tx_busy       = in_tx_busy;
  assign in_poll.hello_reply   = in_hello_reply;
  assign in_poll.profile_reply = in_profile_reply;
  assign in_poll.status_reply  = in_status_reply;

  assign advance   = poll_valid && slot_free;
  assign cfg_ready = 1'b1;

  bls_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_poll    (in_poll),
    .advance    (advance),
    .poll_valid (poll_valid),
    .poll       (poll)
  );

  bls_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .poll      (poll),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  bls_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_request    = out_res.request;
  assign out_phase      = out_res.phase;
  assign out_com_error  = out_res.com_error;
  assign out_locked_out = out_res.locked_out;

endmodule

FILE: rtl/bls_checker.sv
`timescale 1ns / 1ps
module bls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_request,
  input logic [2:0] out_phase,
  input logic       out_com_error,
  input logic       out_locked_out
);

  // lockout is permanent until reset
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_locked_out |=> out_locked_out)
    else $error("lockout cleared without reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_locked_out |-> out_phase == bls_pkg::PH_FAIL)
    else $error("locked out outside fail phase");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_com_error |-> out_locked_out)
    else $error("alarm without lockout");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request == bls_pkg::REQ_STATUS |-> out_phase == bls_pkg::PH_STATUS)
    else $error("status query not followed by status wait");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase) && $stable(out_request))
    else $error("stalled result changed");

endmodule

bind link_bringup_sequencer bls_checker u_bls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_request    (out_request),
  .out_phase      (out_phase),
  .out_com_error  (out_com_error),
  .out_locked_out (out_locked_out)
);

FILE: tb/sv/tb_link_bringup_sequencer.sv
`timescale 1ns / 1ps
module tb_link_bringup_sequencer;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 6;
  localparam int STEER_MAX    = 64;
  localparam int LOCKOUT_MAX  = 4000;
  // indexes past the register list, which the block ignores
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_tick = 1'b0;
  logic        in_tx_busy = 1'b0;
  logic        in_hello_reply = 1'b0;
  logic        in_profile_reply = 1'b0;
  logic        in_status_reply = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_request;
  logic [2:0]  out_phase;
  logic        out_com_error;
  logic        out_locked_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  link_bringup_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_tick(in_tick), .in_tx_busy(in_tx_busy),
    .in_hello_reply(in_hello_reply), .in_profile_reply(in_profile_reply),
    .in_status_reply(in_status_reply),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_request(out_request), .out_phase(out_phase),
    .out_com_error(out_com_error), .out_locked_out(out_locked_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // sequencer shadow state
  logic [bls_pkg::TIMEOUT_W-1:0] reg_timeout   = bls_pkg::TIMEOUT_RST;
  logic [bls_pkg::MAXFAIL_W-1:0] reg_max_fail  = bls_pkg::MAXFAIL_RST;
  bls_pkg::phase_t               model_phase   = bls_pkg::PH_OFF;
  logic [bls_pkg::ELAPSED_W-1:0] model_elapsed = '0;
  logic [2:0]                    model_latches = '0;
  logic [bls_pkg::FAILCNT_W-1:0] model_fails   = '0;
  logic                          model_locked  = 1'b0;
  logic                          model_alarm   = 1'b0;

  bls_pkg::result_t awaited_results[$];
  int               mismatches = 0;
  int               cycles = 0;
  bit               steady = 1'b0;
  int               stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // wait for a reply: advance when latched in time, fail once past the timeout
  function automatic void await_reply(int unsigned latch_bit,
                                      bls_pkg::phase_t next_phase);
    if (model_latches[latch_bit] && model_elapsed < reg_timeout) begin
      model_elapsed = '0;
      model_phase = next_phase;
    end
    if (model_elapsed > reg_timeout) begin
      model_phase = bls_pkg::PH_FAIL;
      model_elapsed = '0;
    end
  endfunction

  function automatic bls_pkg::result_t sequencer_step(bls_pkg::poll_t p);
    bls_pkg::req_t    req;
    bls_pkg::result_t r;
    req = bls_pkg::REQ_NONE;
    if (p.tick && model_elapsed != bls_pkg::ELAPSED_MAX) model_elapsed++;
    if (p.hello_reply)   model_latches[bls_pkg::LATCH_HELLO] = 1'b1;
    if (p.profile_reply) model_latches[bls_pkg::LATCH_PROFILE] = 1'b1;
    if (p.status_reply)  model_latches[bls_pkg::LATCH_STATUS] = 1'b1;
    if (!p.tx_busy) begin
      case (model_phase)
        bls_pkg::PH_OFF: begin
          req = bls_pkg::REQ_HELLO;
          model_phase = bls_pkg::PH_HELLO;
          model_elapsed = '0;
        end
        bls_pkg::PH_HELLO: begin
          await_reply(bls_pkg::LATCH_HELLO, bls_pkg::PH_PROFILE);
          if (model_phase == bls_pkg::PH_PROFILE) req = bls_pkg::REQ_PROFILE;
        end
        bls_pkg::PH_PROFILE: await_reply(bls_pkg::LATCH_PROFILE, bls_pkg::PH_QUERY);
        bls_pkg::PH_QUERY: begin
          req = bls_pkg::REQ_STATUS;
          model_phase = bls_pkg::PH_STATUS;
          model_latches[bls_pkg::LATCH_STATUS] = 1'b0;
          model_elapsed = '0;
        end
        bls_pkg::PH_STATUS: await_reply(bls_pkg::LATCH_STATUS, bls_pkg::PH_QUERY);
        bls_pkg::PH_FAIL: begin
          if (!model_locked) begin
            if (model_elapsed > reg_timeout) begin
              if (model_fails != bls_pkg::FAILCNT_MAX) model_fails++;
              model_elapsed = '0;
              if (model_fails > reg_max_fail) begin
                model_locked = 1'b1;
              end else begin
                model_phase = bls_pkg::PH_OFF;
                model_latches = '0;
              end
            end
          end else begin
            model_alarm = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.request = req;
    r.phase = model_phase;
    r.com_error = model_alarm;
    r.locked_out = model_locked;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    bls_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: req %0d phase %0d err %0b lock %0b",
                                out_request, out_phase, out_com_error, out_locked_out));
      end else begin
        want = awaited_results.pop_front();
        if (out_request !== want.request || out_phase !== want.phase ||
            out_com_error !== want.com_error || out_locked_out !== want.locked_out) begin
          note_mismatch($sformatf(
            {"mismatch: expected req %0d phase %0d err %0b lock %0b,",
             " got req %0d phase %0d err %0b lock %0b"},
            want.request, want.phase, want.com_error, want.locked_out,
            out_request, out_phase, out_com_error, out_locked_out));
        end
      end
    end
  end

  // result side backpressure in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_poll(input bls_pkg::poll_t p);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= p.tick;
    in_tx_busy <= p.tx_busy;
    in_hello_reply <= p.hello_reply;
    in_profile_reply <= p.profile_reply;
    in_status_reply <= p.status_reply;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(sequencer_step(p));
  endtask

  task automatic poll_with(input bit tick, input bit busy, input bit hello,
                           input bit profile, input bit status);
    bls_pkg::poll_t p;
    p.tick = tick;
    p.tx_busy = busy;
    p.hello_reply = hello;
    p.profile_reply = profile;
    p.status_reply = status;
    send_poll(p);
  endtask

  // drop valid, let every pending result come out, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bls_pkg::CFG_TIMEOUT:  reg_timeout = data;
      bls_pkg::CFG_MAX_FAIL: reg_max_fail = data[bls_pkg::MAXFAIL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] timeout, input logic [7:0] max_fail);
    wait_idle();
    write_reg(bls_pkg::CFG_TIMEOUT, timeout);
    write_reg(bls_pkg::CFG_MAX_FAIL, {8'($urandom_range(0, 255)), max_fail});
  endtask

  // drive the sequencer into a given phase: ticks without replies lead to fail
  // and restart, replies without ticks lead through the bring-up chain
  task automatic steer_to(input bls_pkg::phase_t target);
    bit toward_fail;
    int n;
    toward_fail = (target == bls_pkg::PH_OFF || target == bls_pkg::PH_HELLO ||
                   target == bls_pkg::PH_FAIL);
    n = 0;
    while (model_phase != target && n < STEER_MAX) begin
      poll_with(toward_fail || model_phase == bls_pkg::PH_FAIL, 1'b0,
                !toward_fail, !toward_fail, !toward_fail);
      n++;
    end
  endtask

  task automatic test_clean_bringup();
    poll_with(0, 0, 0, 0, 0);
    poll_with(1, 1, 0, 0, 0);
    poll_with(0, 1, 1, 0, 0);
    poll_with(0, 0, 1, 0, 0);
    poll_with(1, 0, 0, 0, 0);
    poll_with(0, 0, 0, 1, 0);
    // status answer in the same poll as the query is dropped
    poll_with(0, 0, 0, 0, 1);
    poll_with(1, 0, 0, 0, 0);
    poll_with(0, 0, 0, 0, 1);
    poll_with(1, 0, 0, 0, 0);
    poll_with(1, 1, 1, 1, 1);
    poll_with(0, 0, 0, 0, 0);
  endtask

  task automatic test_reply_timeout();
    configure(16'd1, 8'd255);
    steer_to(bls_pkg::PH_STATUS);
    poll_with(1, 0, 0, 0, 0);
    poll_with(1, 0, 0, 0, 0);
    poll_with(1, 0, 0, 0, 0);
    poll_with(1, 0, 0, 0, 0);
    steer_to(bls_pkg::PH_PROFILE);
    poll_with(1, 0, 0, 0, 0);
    poll_with(1, 0, 1, 0, 0);
    poll_with(1, 0, 0, 0, 0);
  endtask

  task automatic test_reply_at_limit();
    configure(16'd2, 8'd255);
    steer_to(bls_pkg::PH_HELLO);
    poll_with(1, 0, 0, 0, 0);
    poll_with(1, 0, 0, 0, 0);
    // elapsed equals the timeout: neither advance nor fail
    poll_with(0, 0, 1, 0, 0);
    poll_with(1, 0, 0, 0, 0);
    steer_to(bls_pkg::PH_HELLO);
    poll_with(1, 0, 0, 0, 0);
    poll_with(0, 0, 1, 0, 0);
  endtask

  task automatic test_zero_timeout();
    configure(16'd0, 8'd255);
    steer_to(bls_pkg::PH_HELLO);
    poll_with(0, 0, 1, 0, 0);
    poll_with(1, 0, 1, 0, 0);
    poll_with(1, 0, 0, 0, 0);
    poll_with(0, 0, 0, 0, 0);
  endtask

  task automatic test_register_extremes();
    configure(16'd3, 8'd255);
    steer_to(bls_pkg::PH_HELLO);
    configure(16'hFFFF, 8'd0);
    write_reg(CFG_SPARE_A, 16'($urandom_range(0, 65535)));
    write_reg(CFG_SPARE_B, 16'hFFFF);
    repeat (3) poll_with(1, 0, 1, 0, 0);
    repeat (3) poll_with(1, 0, 0, 1, 0);
    repeat (6) poll_with(1, 0, 0, 0, 1);
  endtask

  task automatic random_polls(input int count);
    bls_pkg::poll_t p;
    for (int i = 0; i < count; i++) begin
      p.tick = $urandom_range(0, 1);
      p.tx_busy = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        p.hello_reply = $urandom_range(0, 1);
        p.profile_reply = $urandom_range(0, 1);
        p.status_reply = $urandom_range(0, 1);
      end else begin
        p.hello_reply = (model_phase == bls_pkg::PH_HELLO) &&
                        ($urandom_range(0, 2) == 0);
        p.profile_reply = (model_phase == bls_pkg::PH_PROFILE) &&
                          ($urandom_range(0, 2) == 0);
        p.status_reply = (model_phase == bls_pkg::PH_STATUS) &&
                         ($urandom_range(0, 2) == 0);
      end
      send_poll(p);
    end
  endtask

  task automatic test_random_traffic();
    int floor_fail;
    for (int ph_i = 0; ph_i < 5; ph_i++) begin
      floor_fail = int'(model_fails) + 40;
      if (floor_fail > 255) floor_fail = 255;
      if (ph_i == 2)
        configure(16'($urandom_range(9, 40)), 8'($urandom_range(floor_fail, 255)));
      else
        configure(16'($urandom_range(1, 8)), 8'd255);
      steady = (ph_i == 4);
      random_polls(100);
    end
  endtask

  task automatic test_lockout();
    int n;
    steady = 1'b1;
    // any failure from here on pushes the count past the limit
    configure(16'd1, 8'd0);
    n = 0;
    while (!model_locked && n < LOCKOUT_MAX) begin
      poll_with(1, 0, 0, 0, 0);
      n++;
    end
    // alarm waits for the next poll not held by tx_busy
    poll_with(1, 1, 0, 0, 0);
    poll_with(0, 0, 0, 0, 0);
    random_polls(20);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_clean_bringup();
    test_reply_timeout();
    test_reply_at_limit();
    test_zero_timeout();
    test_register_extremes();
    test_random_traffic();
    test_lockout();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: link_bringup_sequencer.f
rtl/bls_pkg.sv
rtl/bls_in_stage.sv
rtl/bls_core.sv
rtl/bls_out_stage.sv
rtl/link_bringup_sequencer.sv
rtl/bls_checker.sv
tb/sv/tb_link_bringup_sequencer.sv
